// ----- rtl/ppes_pkg.sv -----
// ppes_pkg: types and constants shared by the particle pool block
// no dependencies
`default_nettype none
package ppes_pkg;
    localparam int PoolSize = 256;
    localparam int SlotW = 8;
    localparam int CntW = 9;
    localparam logic [23:0] AgeMax = 24'hFFFFFF;
    localparam logic [12:0] StepReset = 13'd1092;
    localparam logic [1:0] OpSpawn = 2'd0;
    localparam logic [1:0] OpTick = 2'd1;
    localparam logic [1:0] OpRead = 2'd2;
    localparam logic [1:0] OpUnused = 2'd3;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] slot_index;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] speed_x;
        logic signed [31:0] speed_y;
        logic signed [31:0] speed_z;
        logic [23:0] life_span;
        logic [30:0] fall_rate;
        logic [23:0] drag_rate;
    } t_in_item;

    typedef struct packed {
        logic [7:0] slot_used;
        logic is_active;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [23:0] elapsed;
        logic [8:0] live_count;
    } t_out_item;

    // one particle record as held in the slot memory
    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic [23:0] age;
        logic [23:0] life;
        logic [30:0] grav;
        logic [23:0] drag;
    } t_rec;

    // shared multiplier request
    typedef struct packed {
        logic signed [32:0] a;
        logic [32:0] b;
    } t_mul_req;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -34'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction
endpackage
`default_nettype wire

// ----- rtl/particle_pool_euler_step_top.sv -----
// particle_pool_euler_step_top: pool store, sequencer and output register
// depends on ppes_pkg and ppes_mul
//
// A pool of 256 particles held in one record memory (one read, one write
// port, registered read) plus a flip-flop alive bit per slot. One shared
// multiplier does all the multiplications under a small sequencer. A spawn
// scans the pool for a free or oldest slot, and a tick walks all 256 slots:
// a live slot is read, aged and stepped through S_T0 to S_T7, a slot that
// retires stops after its age update and an empty slot is skipped; the walk
// is bound by the one memory port and the one multiplier. The block takes
// no item while one is in work; the result waits in an output register
// until the receiver takes it.
`default_nettype none
module particle_pool_euler_step_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire logic [12:0] i_cfg_data,
    input  wire logic i_in_valid,
    output logic o_in_stall,
    input  wire ppes_pkg::t_in_item i_in_item,
    output logic o_out_valid,
    input  wire logic i_out_stall,
    output ppes_pkg::t_out_item o_out_item
);
    import ppes_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0, S_SCAN = 4'd1, S_RD = 4'd2, S_RDW = 4'd3,
        S_TRD = 4'd4, S_TW = 4'd5, S_T0 = 4'd6, S_T1 = 4'd7, S_T2 = 4'd8,
        S_T3 = 4'd9, S_T4 = 4'd10, S_T5 = 4'd11, S_T6 = 4'd12, S_T7 = 4'd13,
        S_OUT = 4'd14, S_SPW = 4'd15;

    logic [3:0] r_st, n_st;
    logic [12:0] r_step;
    logic [PoolSize-1:0] r_alive;
    logic [CntW-1:0] r_cnt;
    t_in_item r_in;
    logic [CntW-1:0] r_idx;
    logic [SlotW-1:0] r_best;
    logic [23:0] r_best_age;
    logic r_have_free;
    t_rec r_rec, r_rd;
    logic [32:0] r_tmp;
    t_out_item r_out;
    logic r_ov;

    // record memory
    t_rec mem [PoolSize];
    logic [SlotW-1:0] w_raddr, w_waddr;
    logic w_we;
    t_rec w_wdata;
    always_ff @(posedge i_clk) begin
        r_rd <= mem[w_raddr];
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
    end

    t_mul_req w_req;
    logic signed [66:0] w_prod;
    ppes_mul u_mul (.i_clk(i_clk), .i_req(w_req), .o_prod(w_prod));

    logic [SlotW-1:0] w_slot;
    assign w_slot = r_idx[SlotW-1:0];
    assign o_in_stall = (r_st != S_IDLE) || r_ov;
    assign o_out_valid = r_ov;
    assign o_out_item = r_out;

    // floor-rounded shift of the product
    logic signed [66:0] w_sh16, w_sh32;
    assign w_sh16 = w_prod >>> 16;
    assign w_sh32 = w_prod >>> 32;
    logic [24:0] w_age_sum;
    assign w_age_sum = {1'b0, r_rd.age} + 25'(r_step);
    logic [23:0] w_age_new;
    assign w_age_new = w_age_sum[24] ? AgeMax : w_age_sum[23:0];

    // record with the new age, and the finished record for write-back
    t_rec w_tw_rec, w_t7_rec;
    always_comb begin
        w_tw_rec = r_rd;
        w_tw_rec.age = w_age_new;
        w_t7_rec = r_rec;
        w_t7_rec.pz = sat32(34'(r_rec.pz) + 34'(w_sh16));
    end

    always_comb begin
        w_raddr = w_slot;
        w_req = '0;
        case (r_st)
            S_T0: begin
                w_req.a = 33'($signed({9'd0, r_rec.drag}));
                w_req.b = 33'(r_step);
            end
            S_T1: begin
                w_req.a = 33'(r_rec.vx);
                w_req.b = (w_prod >= 67'sh100000000) ? 33'd0
                        : 33'h100000000 - 33'(w_prod[32:0]);
            end
            S_T2: begin
                w_req.a = 33'(r_rec.vz);
                w_req.b = r_tmp;
            end
            S_T3: begin
                w_req.a = $signed({2'b0, r_rec.grav});
                w_req.b = 33'(r_step);
            end
            S_T4: begin
                w_req.a = 33'(r_rec.vx);
                w_req.b = 33'(r_step);
            end
            S_T5: begin
                w_req.a = 33'(r_rec.vy);
                w_req.b = 33'(r_step);
            end
            S_T6: begin
                w_req.a = 33'(r_rec.vz);
                w_req.b = 33'(r_step);
            end
            default: ;
        endcase
    end

    logic [SlotW-1:0] r_wa;
    logic r_we;
    t_rec r_wd;
    assign w_we = r_we;
    assign w_waddr = r_wa;
    assign w_wdata = r_wd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_step <= StepReset;
            r_alive <= '0;
            r_cnt <= '0;
            r_ov <= 1'b0;
            r_we <= 1'b0;
        end else begin
            // memory write in the cycle after a spawn or a finished slot
            r_we <= (r_st == S_SPW) || (r_st == S_T7);
            if (i_cfg_we) begin
                r_step <= i_cfg_data;
            end
            if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            case (r_st)
                S_IDLE: begin
                    if (i_in_valid && !r_ov) begin
                        r_in <= i_in_item;
                        r_idx <= (i_in_item.opcode == OpRead)
                               ? CntW'(i_in_item.slot_index) : '0;
                        r_have_free <= 1'b0;
                        r_best <= '0;
                        r_best_age <= '0;
                        r_out <= '0;
                        case (i_in_item.opcode)
                            OpSpawn: r_st <= S_SCAN;
                            OpTick:  r_st <= S_TRD;
                            OpRead:  r_st <= S_RD;
                            default: r_st <= S_OUT;
                        endcase
                    end
                end
                // scan: first free slot, else first oldest; each age arrives in the
                // cycle after its address
                S_SCAN: begin
                    if (r_idx != '0 && !r_have_free) begin
                        if (!r_alive[w_slot - 1'b1]) begin
                            r_have_free <= 1'b1;
                            r_best <= w_slot - 1'b1;
                        end else if (r_rd.age > r_best_age || r_idx == CntW'(1)) begin
                            r_best <= w_slot - 1'b1;
                            r_best_age <= r_rd.age;
                        end
                    end
                    if (r_idx == CntW'(PoolSize)) begin
                        r_st <= S_SPW;
                    end
                    r_idx <= r_idx + 1'b1;
                end
                S_SPW: begin
                    r_wa <= r_best;
                    r_wd <= '{px: r_in.start_x, py: r_in.start_y, pz: r_in.start_z,
                              vx: r_in.speed_x, vy: r_in.speed_y, vz: r_in.speed_z,
                              age: 24'd0, life: r_in.life_span,
                              grav: r_in.fall_rate, drag: r_in.drag_rate};
                    if (!r_alive[r_best]) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    r_alive[r_best] <= 1'b1;
                    r_out.slot_used <= r_best;
                    r_out.is_active <= 1'b1;
                    r_out.pos_x <= r_in.start_x;
                    r_out.pos_y <= r_in.start_y;
                    r_out.pos_z <= r_in.start_z;
                    r_st <= S_OUT;
                end
                S_RD: r_st <= S_RDW;
                S_RDW: begin
                    r_out.slot_used <= r_in.slot_index;
                    if (r_alive[w_slot]) begin
                        r_out.is_active <= 1'b1;
                        r_out.pos_x <= r_rd.px;
                        r_out.pos_y <= r_rd.py;
                        r_out.pos_z <= r_rd.pz;
                        r_out.elapsed <= r_rd.age;
                    end
                    r_st <= S_OUT;
                end
                S_TRD: begin
                    if (r_idx == CntW'(PoolSize)) begin
                        r_st <= S_OUT;
                    end else if (!r_alive[w_slot]) begin
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_st <= S_TW;
                    end
                end
                S_TW: begin
                    r_rec <= w_tw_rec;
                    if (w_age_new >= r_rd.life) begin
                        r_alive[w_slot] <= 1'b0;
                        r_cnt <= r_cnt - 1'b1;
                        r_idx <= r_idx + 1'b1;
                        r_st <= S_TRD;
                    end else begin
                        r_st <= S_T0;
                    end
                end
                S_T0: r_st <= S_T1;      // drag*step in flight
                S_T1: r_st <= S_T2;      // vx*d in flight, damping kept in r_tmp
                S_T2: begin
                    r_rec.vx <= w_sh32[31:0];
                    r_st <= S_T3;
                end
                S_T3: begin
                    r_rec.vz <= w_sh32[31:0];
                    r_st <= S_T4;
                end
                S_T4: begin
                    r_rec.vy <= sat32(34'(r_rec.vy) - 34'(w_sh16));
                    r_st <= S_T5;
                end
                S_T5: begin
                    r_rec.px <= sat32(34'(r_rec.px) + 34'(w_sh16));
                    r_st <= S_T6;
                end
                S_T6: begin
                    r_rec.py <= sat32(34'(r_rec.py) + 34'(w_sh16));
                    r_st <= S_T7;
                end
                S_T7: begin
                    r_wa <= w_slot;
                    r_wd <= w_t7_rec;
                    r_idx <= r_idx + 1'b1;
                    r_st <= S_TRD;
                end
                S_OUT: begin
                    r_out.live_count <= r_cnt;
                    r_ov <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
            if (r_st == S_T1) begin
                r_tmp <= w_req.b;
            end
        end
    end
endmodule
`default_nettype wire

// ----- rtl/ppes_mul.sv -----
// ppes_mul: shared registered signed by unsigned multiplier
// depends on ppes_pkg
`default_nettype none
module ppes_mul (
    input  wire logic i_clk,
    input  wire ppes_pkg::t_mul_req i_req,
    output logic signed [66:0] o_prod
);
    import ppes_pkg::*;
    logic signed [66:0] r_prod;
    // operand b is split so each partial product stays near 33x17
    always_ff @(posedge i_clk) begin
        r_prod <= (67'(i_req.a) * $signed({1'b0, 17'(i_req.b[16:0])}))
                + ((67'(i_req.a) * $signed({1'b0, 16'(i_req.b[32:17])})) <<< 17);
    end
    assign o_prod = r_prod;
endmodule
`default_nettype wire

// ----- rtl/ppes_checker.sv -----
// ppes_checker: port-level checks of the particle pool block
// depends on ppes_pkg; bound to particle_pool_euler_step_top
`default_nettype none
module ppes_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_stall,
    input wire logic o_out_valid,
    input wire logic i_out_stall,
    input wire ppes_pkg::t_out_item o_out_item
);
    import ppes_pkg::*;
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall) else $error("input open while result waits");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_item)) else $error("result moved");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.live_count <= CntW'(PoolSize)) else $error("count");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall) else $error("no busy after accept");
endmodule
bind particle_pool_euler_step_top ppes_checker u_chk (.*);
`default_nettype wire

// ----- bench/particle_pool_checker.sv -----
`timescale 1ns / 1ps
// particle_pool_checker: watches both channels of the particle pool, models
// the pool slot by slot and compares every result; depends on ppes_pkg
`default_nettype none
module particle_pool_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire logic [12:0] i_cfg_data,
    input  wire logic i_in_valid,
    input  wire logic i_in_stall,
    input  wire ppes_pkg::t_in_item i_in_item,
    input  wire logic i_out_valid,
    input  wire logic i_out_stall,
    input  wire ppes_pkg::t_out_item i_out_item,
    output int o_mismatches,
    output int o_waiting
);
    import ppes_pkg::*;

    logic [12:0] step_q;
    logic slot_live [PoolSize];
    t_rec slot_rec [PoolSize];
    t_out_item awaited_reports [$];

    function automatic logic signed [31:0] clamp_word(input logic signed [33:0] v);
        if (v > 34'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -34'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // floor(v * m / 2^sh), exact
    function automatic logic signed [31:0] scale_floor(input logic signed [31:0] v,
                                                       input logic [32:0] m,
                                                       input int sh);
        logic signed [66:0] p;
        p = $signed({{35{v[31]}}, v}) * $signed({34'b0, m});
        p = p >>> sh;
        return p[31:0];
    endfunction

    function automatic logic [8:0] live_total();
        logic [8:0] n;
        n = 0;
        for (int i = 0; i < PoolSize; i++) begin
            n += slot_live[i];
        end
        return n;
    endfunction

    task automatic advance_pool();
        logic [24:0] age;
        logic [36:0] loss;
        logic [32:0] damp;
        logic [43:0] fall;
        t_rec r;
        for (int i = 0; i < PoolSize; i++) begin
            if (slot_live[i]) begin
                r = slot_rec[i];
                age = r.age + step_q;
                if (age > AgeMax) begin
                    age = AgeMax;
                end
                r.age = age[23:0];
                if (age[23:0] >= r.life) begin
                    slot_live[i] = 1'b0;
                end else begin
                    loss = r.drag * step_q;
                    damp = (loss >= 37'h100000000) ? 33'd0 : 33'h100000000 - loss[32:0];
                    r.vx = scale_floor(r.vx, damp, 32);
                    r.vz = scale_floor(r.vz, damp, 32);
                    fall = (r.grav * step_q) >> 16;
                    r.vy = clamp_word($signed({{2{r.vy[31]}}, r.vy}) - $signed({6'b0, fall[27:0]}));
                    r.px = clamp_word(34'(r.px) + 34'(scale_floor(r.vx, {20'b0, step_q}, 16)));
                    r.py = clamp_word(34'(r.py) + 34'(scale_floor(r.vy, {20'b0, step_q}, 16)));
                    r.pz = clamp_word(34'(r.pz) + 34'(scale_floor(r.vz, {20'b0, step_q}, 16)));
                end
                slot_rec[i] = r;
            end
        end
    endtask

    // free slot first, otherwise the first of the oldest
    function automatic int spawn_target();
        int best;
        best = 0;
        for (int i = 0; i < PoolSize; i++) begin
            if (!slot_live[i]) begin
                return i;
            end
        end
        for (int i = 1; i < PoolSize; i++) begin
            if (slot_rec[i].age > slot_rec[best].age) begin
                best = i;
            end
        end
        return best;
    endfunction

    task automatic pool_apply(input t_in_item it, output t_out_item rep);
        int s;
        rep = '0;
        case (it.opcode)
            OpSpawn: begin
                s = spawn_target();
                slot_live[s] = 1'b1;
                slot_rec[s] = '{px: it.start_x, py: it.start_y, pz: it.start_z,
                                vx: it.speed_x, vy: it.speed_y, vz: it.speed_z,
                                age: 24'd0, life: it.life_span,
                                grav: it.fall_rate, drag: it.drag_rate};
                rep.slot_used = s[7:0];
                rep.is_active = 1'b1;
                rep.pos_x = it.start_x;
                rep.pos_y = it.start_y;
                rep.pos_z = it.start_z;
            end
            OpTick: begin
                advance_pool();
            end
            OpRead: begin
                s = it.slot_index;
                rep.slot_used = it.slot_index;
                if (slot_live[s]) begin
                    rep.is_active = 1'b1;
                    rep.pos_x = slot_rec[s].px;
                    rep.pos_y = slot_rec[s].py;
                    rep.pos_z = slot_rec[s].pz;
                    rep.elapsed = slot_rec[s].age;
                end
            end
            default: begin
            end
        endcase
        rep.live_count = live_total();
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            o_mismatches++;
            if (o_mismatches <= 10) begin
                $display("mismatch %s: expected %h got %h", name, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            step_q = StepReset;
            for (int i = 0; i < PoolSize; i++) begin
                slot_live[i] = 1'b0;
                slot_rec[i] = '0;
            end
            awaited_reports.delete();
            o_mismatches = 0;
        end else begin
            if (i_cfg_we) begin
                step_q = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                got = i_out_item;
                if (awaited_reports.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10) begin
                        $display("unexpected item: %h", got);
                    end
                end else begin
                    want = awaited_reports.pop_front();
                    check_field("slot_used", want.slot_used, got.slot_used);
                    check_field("is_active", want.is_active, got.is_active);
                    check_field("pos_x", want.pos_x, got.pos_x);
                    check_field("pos_y", want.pos_y, got.pos_y);
                    check_field("pos_z", want.pos_z, got.pos_z);
                    check_field("elapsed", want.elapsed, got.elapsed);
                    check_field("live_count", want.live_count, got.live_count);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pool_apply(i_in_item, want);
                awaited_reports = {awaited_reports, want};
            end
        end
        o_waiting = awaited_reports.size();
    end
endmodule
`default_nettype wire

// ----- bench/particle_pool_euler_step_top_test.sv -----
`timescale 1ns / 1ps
// particle_pool_euler_step_top_test: stimulus, step settings and verdict
// depends on ppes_pkg, particle_pool_checker and particle_pool_euler_step_top
`default_nettype none
module particle_pool_euler_step_top_test;
    import ppes_pkg::*;

    // a tick walks the whole pool, plus a long receiver hold
    localparam int IdleLimit = 20000;
    localparam int HoldCycles = 400;
    localparam int PhaseItems = 160;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [12:0] i_cfg_data;
    logic i_in_valid;
    logic o_in_stall;
    t_in_item i_in_item;
    logic o_out_valid;
    logic i_out_stall;
    t_out_item o_out_item;

    int mismatches;
    int waiting;
    int idle_cycles;
    bit gaps_on;
    int hold_asks;
    int hold_done;

    particle_pool_euler_step_top DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_item(i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item(o_out_item)
    );

    particle_pool_checker u_checker (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .i_in_stall(o_in_stall),
        .i_in_item(i_in_item),
        .i_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_out_item(o_out_item),
        .o_mismatches(mismatches),
        .o_waiting(waiting)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // mostly short gaps, a few long ones, none at all while gaps are off
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // word with a bias toward the extremes and toward small values
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2, 3: return $urandom;
            default: return $signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh00FFFFFF;
        endcase
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        int r;
        it.slot_index = 8'($urandom_range(0, 255));
        it.start_x = pick_word();
        it.start_y = pick_word();
        it.start_z = pick_word();
        it.speed_x = pick_word();
        it.speed_y = pick_word();
        it.speed_z = pick_word();
        // mostly long lives so the pool fills and the oldest slot gets reused
        r = $urandom_range(0, 19);
        if (r == 0) begin
            it.life_span = 24'd0;
        end else if (r < 5) begin
            it.life_span = 24'($urandom_range(655, 30000));
        end else begin
            it.life_span = 24'($urandom);
        end
        it.fall_rate = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 22));
        it.drag_rate = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 1 << 18));
        r = $urandom_range(0, 99);
        if (r < 42) begin
            it.opcode = OpSpawn;
        end else if (r < 56) begin
            it.opcode = OpTick;
        end else if (r < 95) begin
            it.opcode = OpRead;
        end else begin
            it.opcode = OpUnused;
        end
        return it;
    endfunction

    // valid stays high straight into the next item when there is no gap
    task automatic offer(input t_in_item it);
        int gap;
        gap = gap_len();
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_item = it;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
    endtask

    // stop offering and wait until every report is back
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (waiting != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_step(input logic [12:0] v);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic offer_op(input logic [1:0] op, input logic [7:0] slot);
        t_in_item it;
        it = random_item();
        it.opcode = op;
        it.slot_index = slot;
        offer(it);
    endtask

    // receiver: random stalls, plus one long hold when asked
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_asks != hold_done) begin
                hold_done = hold_asks;
                i_out_stall = 1'b1;
                repeat (HoldCycles - 1) @(negedge i_clk);
            end else begin
                i_out_stall = gaps_on && ($urandom_range(0, 99) < 30);
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IdleLimit) begin
            $display("particle_pool_euler_step_top_test: done, errors");
            $finish;
        end
    end

    initial begin
        t_in_item it;
        logic [12:0] steps [5];
        gaps_on = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty pool, extremes, zero lifetime, reads of empty slots
        offer_op(OpRead, 8'd0);
        offer_op(OpTick, 8'd0);
        offer_op(OpUnused, 8'd0);
        it = '0;
        it.opcode = OpSpawn;
        it.start_x = 32'sh7FFFFFFF;
        it.start_y = 32'sh7FFFFFFF;
        it.start_z = 32'sh7FFFFFFF;
        it.speed_x = 32'sh7FFFFFFF;
        it.speed_y = 32'sh7FFFFFFF;
        it.speed_z = 32'sh7FFFFFFF;
        it.life_span = 24'hFFFFFF;
        it.fall_rate = 31'h7FFFFFFF;
        it.drag_rate = 24'd0;
        it.slot_index = 8'hFF;
        offer(it);
        it.start_x = 32'sh80000000;
        it.start_y = 32'sh80000000;
        it.start_z = 32'sh80000000;
        it.speed_x = 32'sh80000000;
        it.speed_y = 32'sh80000000;
        it.speed_z = 32'sh80000000;
        it.fall_rate = 31'h7FFFFFFF;
        it.drag_rate = 24'hFFFFFF;
        offer(it);
        it.life_span = 24'd0;           // retired on its first tick
        it.fall_rate = 31'd0;
        it.drag_rate = 24'd65536;
        offer(it);
        it.life_span = 24'd655;
        it.start_y = 32'sh00010000;
        it.speed_x = 32'sh00020000;
        it.speed_y = -32'sh00030000;
        it.fall_rate = 31'd642252;
        offer(it);
        for (int i = 0; i < 5; i++) begin
            offer_op(OpRead, 8'(i));
        end
        offer_op(OpRead, 8'd255);
        offer_op(OpTick, 8'd0);
        for (int i = 0; i < 5; i++) begin
            offer_op(OpRead, 8'(i));
        end
        offer_op(OpTick, 8'd0);
        offer_op(OpRead, 8'd1);
        offer_op(OpRead, 8'd3);

        // random phases, each under its own step, extremes included
        steps[0] = 13'd0;
        steps[1] = 13'h1FFF;
        steps[2] = 13'd273;
        steps[3] = 13'd4369;
        steps[4] = 13'($urandom_range(273, 4369));
        for (int p = 0; p < 5; p++) begin
            drain();
            write_step(steps[p]);
            for (int n = 0; n < PhaseItems; n++) begin
                if (n % 40 == 0) begin
                    gaps_on = $urandom_range(0, 3) != 0;
                end
                // long receiver hold while reads keep coming, so the block backs up
                if (p == 1 && n == 20) begin
                    hold_asks++;
                    repeat (12) offer_op(OpRead, 8'($urandom_range(0, 255)));
                end
                // sender waits for every report to come back
                if (n == 80) begin
                    drain();
                end
                offer(random_item());
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("particle_pool_euler_step_top_test: done, clean");
        end else begin
            $display("particle_pool_euler_step_top_test: done, errors");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- files.f -----
rtl/ppes_pkg.sv
rtl/ppes_mul.sv
rtl/particle_pool_euler_step_top.sv
rtl/ppes_checker.sv
bench/particle_pool_checker.sv
bench/particle_pool_euler_step_top_test.sv
